// File: rtl/wfc_pkg.sv
`default_nettype none
package wfc_pkg;

  localparam int TableEntries = 1024;
  localparam int WordBytes    = 32;
  localparam int CountBits    = 32;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharTab   = 8'h09;

  localparam int IdxMaxBits = 16;

  // Search token that travels down the row of table cells.
  typedef struct packed {
    logic                  valid;
    logic                  found;
    logic                  ins;
    logic [IdxMaxBits-1:0] idx;
    logic [31:0]           count;
  } token_t;

endpackage
`default_nettype wire

// File: rtl/wfc_if.sv
`default_nettype none
interface wfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;
  modport source (output valid, byte_value, last_byte, input ready);
  modport sink (input valid, byte_value, last_byte, output ready);
endinterface

interface wfc_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [9:0]  entry_index;
  logic [31:0] entry_count;
  logic        word_truncated;
  logic        table_full;
  logic [31:0] line_total;
  logic [31:0] word_total;
  logic [10:0] distinct_total;
  logic        last_result;
  modport source (output valid, result_kind, entry_index, entry_count, word_truncated,
                  table_full, line_total, word_total, distinct_total, last_result,
                  input ready);
  modport sink (input valid, result_kind, entry_index, entry_count, word_truncated,
                table_full, line_total, word_total, distinct_total, last_result,
                output ready);
endinterface
`default_nettype wire

// File: rtl/wfc_cell.sv
`default_nettype none
module wfc_cell #(
  parameter int IDX           = 0,
  parameter int TABLE_ENTRIES = wfc_pkg::TableEntries,
  parameter int WORD_BYTES    = wfc_pkg::WordBytes,
  parameter int COUNT_BITS    = wfc_pkg::CountBits
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire wfc_pkg::token_t                      tok_i,
  output wfc_pkg::token_t                           tok_o,
  input  wire logic [WORD_BYTES*8-1:0]              word_i,
  input  wire logic [$clog2(WORD_BYTES+1)-1:0]      len_i,
  input  wire logic [$clog2(TABLE_ENTRIES+1)-1:0]   used_i
);
  localparam int LW = $clog2(WORD_BYTES + 1);
  localparam int UW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [WORD_BYTES*8-1:0] text_q;
  logic [LW-1:0]           len_q;
  logic [COUNT_BITS-1:0]   tally_q;
  logic [COUNT_BITS-1:0]   tally_d;
  wfc_pkg::token_t         tok_q, tok_d;
  logic                    open_w, hit_w, ins_w;

  always_comb begin
    open_w  = tok_i.valid && !tok_i.found;
    hit_w   = open_w && (UW'(IDX) < used_i) && (len_q == len_i) && (text_q == word_i);
    ins_w   = open_w && (UW'(IDX) == used_i);
    tally_d = (tally_q == CountMax) ? tally_q : tally_q + 1'b1;
    tok_d   = tok_i;
    if (hit_w) begin
      tok_d.found = 1'b1;
      tok_d.idx   = wfc_pkg::IdxMaxBits'(IDX);
      tok_d.count = 32'(tally_d);
    end else if (ins_w) begin
      tok_d.found = 1'b1;
      tok_d.ins   = 1'b1;
      tok_d.idx   = wfc_pkg::IdxMaxBits'(IDX);
      tok_d.count = 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_w) begin
      tally_q <= tally_d;
    end else if (ins_w) begin
      text_q  <= word_i;
      len_q   <= len_i;
      tally_q <= COUNT_BITS'(1);
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

// File: rtl/word_frequency_counter.sv
`default_nettype none
// Channel   Direction  Payload
// byte_i    in         byte_value[7:0], last_byte
// result_o  out        result_kind, entry_index, entry_count, word_truncated, table_full,
//                      line_total, word_total, distinct_total, last_result
//
// A byte that ends neither a word nor a message returns straight to idle, and a last byte that
// ends no word goes on to the total result. A byte that ends a word launches the search token
// down the row of table cells, then the word result, then the total if it is the last byte.
// Reset clears the control state and empties the table at once; no clearing pass.
// A stalled result transaction holds the block after its search, and a new byte is taken
// only when no search is running and no result waits to be loaded into the output.
module word_frequency_counter #(
  parameter int TABLE_ENTRIES = wfc_pkg::TableEntries,
  parameter int WORD_BYTES    = wfc_pkg::WordBytes,
  parameter int COUNT_BITS    = wfc_pkg::CountBits
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  wfc_byte_if.sink   byte_i,
  wfc_result_if.source result_o
);
  localparam int LW = $clog2(WORD_BYTES + 1);
  localparam int BW = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam int UW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_WORD, S_TOTAL} state_e;

  state_e                  state_q;
  logic [WORD_BYTES*8-1:0] word_q, word_d;
  logic [LW-1:0]           len_q, len_d;
  logic                    cut_q, cut_d;
  logic                    in_word_q, in_line_q, last_q, start_q;
  logic [31:0]             lines_q, lines_d, words_q;
  logic [UW-1:0]           used_q;
  wfc_pkg::token_t         res_q;
  wfc_pkg::token_t         tok [TABLE_ENTRIES+1];
  logic                    acc_w, delim_w, finish_w, out_free_w;
  logic [31:0]             used_ext_w, idx_ext_w;

  logic                    o_valid_q, o_kind_q, o_cut_q, o_full_q, o_last_q;
  logic [9:0]              o_idx_q;
  logic [31:0]             o_count_q, o_lines_q, o_words_q;
  logic [10:0]             o_dist_q;

  assign acc_w      = byte_i.valid && byte_i.ready;
  assign out_free_w = !o_valid_q || result_o.ready;
  assign used_ext_w = 32'(used_q);
  assign idx_ext_w  = 32'(res_q.idx);

  always_comb begin
    delim_w = (byte_i.byte_value == wfc_pkg::CharSpace) || (byte_i.byte_value == wfc_pkg::CharCr)
           || (byte_i.byte_value == wfc_pkg::CharLf) || (byte_i.byte_value == wfc_pkg::CharTab);
    finish_w = (in_word_q || !delim_w) && (delim_w || byte_i.last_byte);
    lines_d  = lines_q;
    if ((byte_i.byte_value != wfc_pkg::CharLf) && !in_line_q && (lines_q != '1)) begin
      lines_d = lines_q + 32'd1;
    end
    word_d = in_word_q ? word_q : '0;
    len_d  = in_word_q ? len_q : '0;
    cut_d  = in_word_q ? cut_q : 1'b0;
    if (!delim_w) begin
      if (len_d < LW'(WORD_BYTES)) begin
        word_d[len_d[BW-1:0]*8 +: 8] = byte_i.byte_value;
        len_d = len_d + 1'b1;
      end else begin
        cut_d = 1'b1;
      end
    end
  end

  assign tok[0] = '{valid: start_q, found: 1'b0, ins: 1'b0, idx: '0, count: '0};

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    wfc_cell #(
      .IDX(g), .TABLE_ENTRIES(TABLE_ENTRIES), .WORD_BYTES(WORD_BYTES), .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk_i (clk_i), .rst_ni(rst_ni), .tok_i(tok[g]), .tok_o(tok[g+1]),
      .word_i(word_q), .len_i(len_q), .used_i(used_q)
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= '0;
      cut_q     <= 1'b0;
      in_word_q <= 1'b0;
      in_line_q <= 1'b0;
      last_q    <= 1'b0;
      start_q   <= 1'b0;
      lines_q   <= '0;
      words_q   <= '0;
      used_q    <= '0;
      o_valid_q <= 1'b0;
    end else begin
      start_q <= (state_q == S_IDLE) && acc_w && finish_w;
      if (o_valid_q && result_o.ready && (state_q != S_WORD) && (state_q != S_TOTAL)) begin
        o_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc_w) begin
            in_line_q <= (byte_i.byte_value != wfc_pkg::CharLf);
            lines_q   <= lines_d;
            len_q     <= len_d;
            cut_q     <= cut_d;
            in_word_q <= (in_word_q || !delim_w) && !finish_w;
            last_q    <= byte_i.last_byte;
            if (finish_w) begin
              if (words_q != '1) begin
                words_q <= words_q + 32'd1;
              end
              state_q <= S_SEARCH;
            end else if (byte_i.last_byte) begin
              state_q <= S_TOTAL;
            end
          end
        end
        S_SEARCH: begin
          if (tok[TABLE_ENTRIES].valid) begin
            if (tok[TABLE_ENTRIES].ins) begin
              used_q <= used_q + 1'b1;
            end
            state_q <= S_WORD;
          end
        end
        S_WORD: begin
          if (out_free_w) begin
            o_valid_q <= 1'b1;
            o_kind_q  <= 1'b0;
            o_idx_q   <= res_q.found ? idx_ext_w[9:0] : '0;
            o_count_q <= res_q.found ? res_q.count : '0;
            o_cut_q   <= cut_q;
            o_full_q  <= !res_q.found;
            o_lines_q <= '0;
            o_words_q <= '0;
            o_dist_q  <= '0;
            o_last_q  <= !last_q;
            state_q   <= last_q ? S_TOTAL : S_IDLE;
          end
        end
        S_TOTAL: begin
          if (out_free_w) begin
            o_valid_q <= 1'b1;
            o_kind_q  <= 1'b1;
            o_idx_q   <= '0;
            o_count_q <= '0;
            o_cut_q   <= 1'b0;
            o_full_q  <= 1'b0;
            o_lines_q <= lines_q;
            o_words_q <= words_q;
            o_dist_q  <= used_ext_w[10:0];
            o_last_q  <= 1'b1;
            used_q    <= '0;
            in_word_q <= 1'b0;
            in_line_q <= 1'b0;
            lines_q   <= '0;
            words_q   <= '0;
            len_q     <= '0;
            cut_q     <= 1'b0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && acc_w) begin
      word_q <= word_d;
    end
    if (tok[TABLE_ENTRIES].valid) begin
      res_q <= tok[TABLE_ENTRIES];
    end
  end

  assign byte_i.ready            = (state_q == S_IDLE);
  assign result_o.valid          = o_valid_q;
  assign result_o.result_kind    = o_kind_q;
  assign result_o.entry_index    = o_idx_q;
  assign result_o.entry_count    = o_count_q;
  assign result_o.word_truncated = o_cut_q;
  assign result_o.table_full     = o_full_q;
  assign result_o.line_total     = o_lines_q;
  assign result_o.word_total     = o_words_q;
  assign result_o.distinct_total = o_dist_q;
  assign result_o.last_result    = o_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[TABLE_ENTRIES].valid |-> state_q == S_SEARCH)
    else $error("Search token left the chain outside a search.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(TABLE_ENTRIES))
    else $error("Entry count exceeds the table size.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok[TABLE_ENTRIES].valid && !tok[TABLE_ENTRIES].found) |-> used_q == UW'(TABLE_ENTRIES))
    else $error("Search failed while the table had room.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |=> !start_q)
    else $error("Search started twice in a row.");

endmodule
`default_nettype wire
